### rtl/crc16_packet_framer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC16 packet framer checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef CRC16_PACKET_FRAMER_DEFINES_SVH
`define CRC16_PACKET_FRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRCPF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crcpf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRCPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crcpf assertion failed");

`endif

### rtl/crcpf_pkg.sv
// ----------------------------------------------------------------------------
// crcpf_pkg
// Types, codes and the CRC16-CCITT byte update shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crcpf_pkg;

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BYTE  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_VERSION = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD    = 8'd3;

    // CRC16-CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Bytes in a frame besides the payload: two sync, five header, two CRC.
    localparam logic [16:0] FRAME_OVERHEAD = 17'd9;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_OUTSIDE  = 2'd3
    } t_status;

    // Sequencer step within one item.
    typedef logic [3:0] t_step;

    // Steps of a start item.
    localparam t_step STEP_SYNC0   = 4'd0;
    localparam t_step STEP_SYNC1   = 4'd1;
    localparam t_step STEP_VERSION = 4'd2;
    localparam t_step STEP_TYPE    = 4'd3;
    localparam t_step STEP_SEQ_LO  = 4'd4;
    localparam t_step STEP_SEQ_HI  = 4'd5;
    localparam t_step STEP_COUNT   = 4'd6;
    localparam t_step STEP_CRC_LO  = 4'd7;
    localparam t_step STEP_CRC_HI  = 4'd8;

    // Steps of a payload item.
    localparam t_step PSTEP_DATA   = 4'd0;
    localparam t_step PSTEP_CRC_LO = 4'd1;
    localparam t_step PSTEP_CRC_HI = 4'd2;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] format_version;
        logic [7:0] max_payload;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic        func;
        logic [7:0]  frame_type;
        logic [15:0] sequence_req;
        logic [7:0]  payload_count;
        logic [15:0] room;
        logic [7:0]  payload_byte;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       run_last;
        logic       frame_end;
    } t_result;

    // Folds one byte into the CRC, MSB first, without reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### rtl/crcpf_cfg.sv
// ----------------------------------------------------------------------------
// crcpf_cfg
// Configuration registers of the framer, written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [crcpf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    output crcpf_pkg::t_cfg                      o_cfg
);
    import crcpf_pkg::*;

    t_cfg r_cfg;

    // The registers take a write in every cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; writes to unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= 8'h00;
            r_cfg.sync_second    <= 8'h00;
            r_cfg.format_version <= 8'h00;
            r_cfg.max_payload    <= 8'hFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_FIRST:     r_cfg.sync_first     <= i_cfg_data;
                REG_SYNC_SECOND:    r_cfg.sync_second    <= i_cfg_data;
                REG_FORMAT_VERSION: r_cfg.format_version <= i_cfg_data;
                REG_MAX_PAYLOAD:    r_cfg.max_payload    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/crcpf_seq.sv
// ----------------------------------------------------------------------------
// crcpf_seq
// Holds one input item and emits its results one per cycle unless stalled,
// updating the frame state and the running CRC as each byte goes out.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crcpf_pkg::t_cfg   i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire crcpf_pkg::t_item  i_item,
    input  wire logic              i_res_ready,
    output logic                   o_res_valid,
    output crcpf_pkg::t_result     o_res
);
    import crcpf_pkg::*;

    // Item register and frame state. A frame is open exactly when payload
    // bytes are still expected, so the byte count doubles as the open flag.
    logic        r_vld;
    t_item       r_item;
    t_step       r_step;
    logic [15:0] r_crc;
    logic [7:0]  r_left;

    logic        n_last;
    t_step       n_step;
    logic [15:0] n_crc;
    logic [7:0]  n_left;
    t_result     res;

    logic        emit;
    logic        too_long;
    logic        no_room;
    logic [7:0]  crc_data;
    logic [15:0] crc_seed;
    logic [15:0] crc_next;

    assign emit = r_vld && i_res_ready;

    // Frame checks of a start item.
    assign too_long = r_item.payload_count > i_cfg.max_payload;
    assign no_room  = {1'b0, r_item.room} < ({9'd0, r_item.payload_count} + FRAME_OVERHEAD);

    // Byte that enters the CRC in this step.
    always_comb begin
        crc_data = r_item.payload_byte;
        if (r_item.func == FUNC_START) begin
            case (r_step)
                STEP_VERSION: crc_data = i_cfg.format_version;
                STEP_TYPE:    crc_data = r_item.frame_type;
                STEP_SEQ_LO:  crc_data = r_item.sequence_req[7:0];
                STEP_SEQ_HI:  crc_data = r_item.sequence_req[15:8];
                STEP_COUNT:   crc_data = r_item.payload_count;
                default:      crc_data = r_item.payload_byte;
            endcase
        end
    end

    // The header CRC restarts from the initial value at the version byte.
    assign crc_seed = (r_item.func == FUNC_START && r_step == STEP_VERSION) ? CRC_INIT : r_crc;
    assign crc_next = crc_byte(crc_seed, crc_data);

    // Result of the current step and the state it leaves behind.
    always_comb begin
        res    = '0;
        n_last = 1'b0;
        n_crc  = r_crc;
        n_left = r_left;
        if (r_item.func == FUNC_START) begin
            case (r_step)
                STEP_SYNC0: begin
                    if (too_long) begin
                        res.status = ST_TOO_LONG;
                        n_last     = 1'b1;
                    end else if (no_room) begin
                        res.status = ST_NO_ROOM;
                        n_last     = 1'b1;
                    end else begin
                        res.out_byte = i_cfg.sync_first;
                    end
                end
                STEP_SYNC1: begin
                    res.out_byte = i_cfg.sync_second;
                end
                STEP_VERSION, STEP_TYPE, STEP_SEQ_LO, STEP_SEQ_HI: begin
                    res.out_byte = crc_data;
                    n_crc        = crc_next;
                end
                STEP_COUNT: begin
                    // The frame opens here, or closes with the CRC when empty.
                    res.out_byte = crc_data;
                    n_crc        = crc_next;
                    n_left       = r_item.payload_count;
                    n_last       = r_item.payload_count != 8'd0;
                end
                STEP_CRC_LO: begin
                    res.out_byte = r_crc[7:0];
                end
                STEP_CRC_HI: begin
                    res.out_byte  = r_crc[15:8];
                    res.frame_end = 1'b1;
                    n_last        = 1'b1;
                    n_crc         = CRC_INIT;
                end
                default: begin
                    n_last = 1'b1;
                end
            endcase
        end else begin
            case (r_step)
                PSTEP_DATA: begin
                    if (r_left == 8'd0) begin
                        res.status = ST_OUTSIDE;
                        n_last     = 1'b1;
                    end else begin
                        res.out_byte = r_item.payload_byte;
                        n_crc        = crc_next;
                        n_left       = r_left - 8'd1;
                        n_last       = r_left != 8'd1;
                    end
                end
                PSTEP_CRC_LO: begin
                    res.out_byte = r_crc[7:0];
                end
                PSTEP_CRC_HI: begin
                    res.out_byte  = r_crc[15:8];
                    res.frame_end = 1'b1;
                    n_last        = 1'b1;
                    n_crc         = CRC_INIT;
                end
                default: begin
                    n_last = 1'b1;
                end
            endcase
        end
        res.run_last = n_last;
    end

    assign n_step      = n_last ? STEP_SYNC0 : r_step + 4'd1;
    assign o_in_ready  = !r_vld || (emit && n_last);
    assign o_res_valid = r_vld;
    assign o_res       = res;

    // Control and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_step <= STEP_SYNC0;
            r_crc  <= CRC_INIT;
            r_left <= 8'd0;
        end else begin
            if (emit) begin
                r_step <= n_step;
                r_crc  <= n_crc;
                r_left <= n_left;
            end
            if (i_in_valid && o_in_ready) begin
                r_vld <= 1'b1;
            end else if (emit && n_last) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Item payload register.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/crcpf_obuf.sv
// ----------------------------------------------------------------------------
// crcpf_obuf
// Output register with a skid stage, so the ready seen by the sequencer is
// a register and not the downstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_obuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push_valid,
    output logic                     o_push_ready,
    input  wire crcpf_pkg::t_result  i_push,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output crcpf_pkg::t_result       o_out
);
    import crcpf_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;

    logic    push;
    logic    pop;

    assign o_push_ready = !r_skid_vld;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = r_out_vld && i_out_ready;
    assign o_out_valid  = r_out_vld;
    assign o_out        = r_out;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (r_out_vld && !pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result data: the skid entry drains first, to keep the order.
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_vld && !pop) begin
                r_skid <= i_push;
            end else begin
                r_out <= i_push;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/crc16_packet_framer.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer
// Builds framed packets with a CRC16-CCITT-FALSE trailer as a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_in_valid/o_in_ready) are either a start request
//   (i_func = 0) or one payload byte (i_func = 1). A start beat gives seven
//   header beats on the output, or nine when the payload is empty (CRC low
//   then high byte). A payload beat gives one output beat, or three on the
//   last byte of the frame. A rejected start or a byte outside a frame gives
//   a single error beat. o_run_last marks the last output beat of each input.
//   Output beats leave one per cycle while the receiver is ready; an input
//   beat is taken in the cycle its predecessor's last output beat is
//   produced, so payload bytes stream at one per cycle when nothing stalls,
//   and a start occupies the one-byte-per-cycle sequencer, with its per-byte
//   CRC update, for all of its header beats. An accepted input beat passes
//   through the item register, then the output register, to the output.
//   The configuration port takes a write in every cycle and should only be
//   written while the framer is idle.
//   Reset clears all frame state and the registers to their defaults. When
//   the receiver stalls, a skid stage holds one extra result and the input
//   stalls behind it; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_framer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [crcpf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_func,
    input  wire logic [7:0]                        i_frame_type,
    input  wire logic [15:0]                       i_sequence_req,
    input  wire logic [7:0]                        i_payload_count,
    input  wire logic [15:0]                       i_room,
    input  wire logic [7:0]                        i_payload_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [7:0]                             o_out_byte,
    output logic [1:0]                             o_status,
    output logic                                   o_run_last,
    output logic                                   o_frame_end
);
    import crcpf_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result seq_res;
    t_result out_res;
    logic    seq_valid;
    logic    seq_ready;

    // Pack the input ports into one item.
    assign item.func          = i_func;
    assign item.frame_type    = i_frame_type;
    assign item.sequence_req  = i_sequence_req;
    assign item.payload_count = i_payload_count;
    assign item.room          = i_room;
    assign item.payload_byte  = i_payload_byte;

    crcpf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crcpf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (item),
        .i_res_ready (seq_ready),
        .o_res_valid (seq_valid),
        .o_res       (seq_res)
    );

    crcpf_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (seq_valid),
        .o_push_ready (seq_ready),
        .i_push       (seq_res),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (out_res)
    );

    // Unpack the result onto the output ports.
    assign o_out_byte  = out_res.out_byte;
    assign o_status    = out_res.status;
    assign o_run_last  = out_res.run_last;
    assign o_frame_end = out_res.frame_end;

endmodule

`default_nettype wire

### rtl/crcpf_checker.sv
// ----------------------------------------------------------------------------
// crcpf_checker
// Port-level assertions for the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_framer_defines.svh"

module crcpf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_status,
    input wire logic       o_run_last,
    input wire logic       o_frame_end
);
    import crcpf_pkg::*;

    // A stalled result beat stays offered.
    `CRCPF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result beat keeps its byte and status.
    `CRCPF_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready,
        $stable(o_out_byte) && $stable(o_status))

    // The closing CRC byte ends its input's run and is never an error.
    `CRCPF_ASSERT_SAME(a_end_is_last, o_out_valid && o_frame_end,
        o_run_last && (o_status == ST_OK))

    // Error beats carry a zero byte, stand alone and never close a frame.
    `CRCPF_ASSERT_SAME(a_error_beat, o_out_valid && (o_status != ST_OK),
        (o_out_byte == 8'd0) && o_run_last && !o_frame_end)

endmodule

bind crc16_packet_framer crcpf_checker u_crcpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_status    (o_status),
    .o_run_last  (o_run_last),
    .o_frame_end (o_frame_end)
);

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the CRC16 packet framer
// Drives start requests and payload bytes into the framer, predicts every
// output beat (header, payload, CRC trailer and error beats) with an
// independent model, and checks each output beat in order. Directed tests
// cover the field extremes and every error case; random traffic of mostly
// well-formed frames follows under three different stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcpf_pkg::*;

    // Clock, reset and the signals towards the framer.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_item                  in_item   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             out_byte;
    logic [1:0]             out_status;
    logic                   out_run_last;
    logic                   out_frame_end;

    // Stall mix, in percent of cycles.
    int send_idle_pct = 11;
    int recv_idle_pct = 81;

    // Framer model: configuration and frame state.
    t_cfg        cfg_model = '{sync_first: 8'h00, sync_second: 8'h00,
                               format_version: 8'h00, max_payload: 8'hFF};
    logic        model_open  = 1'b0;
    logic [7:0]  model_left  = 8'h00;
    logic [15:0] model_crc   = CRC_INIT;

    // Output beats still to come, oldest first.
    t_result frame_beats_q[$];

    // Run statistics.
    int fail_count    = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int frames_closed = 0;
    int error_beats   = 0;

    crc16_packet_framer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_func          (in_item.func),
        .i_frame_type    (in_item.frame_type),
        .i_sequence_req  (in_item.sequence_req),
        .i_payload_count (in_item.payload_count),
        .i_room          (in_item.room),
        .i_payload_byte  (in_item.payload_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_byte      (out_byte),
        .o_status        (out_status),
        .o_run_last      (out_run_last),
        .o_frame_end     (out_frame_end)
    );

    // 500 MHz clock.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver side: stall at random according to the current mix.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // CRC16-CCITT-FALSE, folded in one data bit at a time, MSB first.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic        feedback;
        crc = crc_in;
        for (int b = 7; b >= 0; b--) begin
            feedback = crc[15] ^ data[b];
            crc      = {crc[14:0], 1'b0};
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void push_beat(input logic [7:0] data, input t_status st,
                                      input logic last, input logic fend);
        t_result r;
        r.out_byte  = data;
        r.status    = st;
        r.run_last  = last;
        r.frame_end = fend;
        frame_beats_q.push_back(r);
    endfunction

    // Works out the output beats of one accepted input beat and updates
    // the model's frame state.
    function automatic void predict_beats(input t_item it);
        logic [7:0]  hdr [0:4];
        logic [15:0] crc;
        if (it.func == FUNC_START) begin
            if (it.payload_count > cfg_model.max_payload) begin
                push_beat(8'h00, ST_TOO_LONG, 1'b1, 1'b0);
            end else if ({1'b0, it.room} < {9'd0, it.payload_count} + FRAME_OVERHEAD) begin
                push_beat(8'h00, ST_NO_ROOM, 1'b1, 1'b0);
            end else begin
                hdr[0] = cfg_model.format_version;
                hdr[1] = it.frame_type;
                hdr[2] = it.sequence_req[7:0];
                hdr[3] = it.sequence_req[15:8];
                hdr[4] = it.payload_count;
                crc    = CRC_INIT;
                push_beat(cfg_model.sync_first, ST_OK, 1'b0, 1'b0);
                push_beat(cfg_model.sync_second, ST_OK, 1'b0, 1'b0);
                for (int i = 0; i < 5; i++) begin
                    crc = crc16_fold(crc, hdr[i]);
                    push_beat(hdr[i], ST_OK, (i == 4) && (it.payload_count != 8'd0), 1'b0);
                end
                // An empty payload closes the frame straight away.
                if (it.payload_count == 8'd0) begin
                    push_beat(crc[7:0], ST_OK, 1'b0, 1'b0);
                    push_beat(crc[15:8], ST_OK, 1'b1, 1'b1);
                    model_open = 1'b0;
                    model_left = 8'd0;
                    model_crc  = CRC_INIT;
                end else begin
                    model_open = 1'b1;
                    model_left = it.payload_count;
                    model_crc  = crc;
                end
            end
        end else if (!model_open || model_left == 8'd0) begin
            push_beat(8'h00, ST_OUTSIDE, 1'b1, 1'b0);
        end else begin
            model_crc  = crc16_fold(model_crc, it.payload_byte);
            model_left = model_left - 8'd1;
            if (model_left != 8'd0) begin
                push_beat(it.payload_byte, ST_OK, 1'b1, 1'b0);
            end else begin
                push_beat(it.payload_byte, ST_OK, 1'b0, 1'b0);
                push_beat(model_crc[7:0], ST_OK, 1'b0, 1'b0);
                push_beat(model_crc[15:8], ST_OK, 1'b1, 1'b1);
                model_open = 1'b0;
                model_crc  = CRC_INIT;
            end
        end
    endfunction

    // Output checker: every accepted output beat against the oldest prediction.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            beats_checked++;
            if (out_frame_end) frames_closed++;
            if (out_status != ST_OK) error_beats++;
            if (frame_beats_q.size() == 0) begin
                $error("unexpected output beat: out_byte %0h status %0d", out_byte, out_status);
                fail_count++;
            end else begin
                want = frame_beats_q.pop_front();
                if (out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
                    fail_count++;
                end
                if (out_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_status);
                    fail_count++;
                end
                if (out_run_last !== want.run_last) begin
                    $error("run_last: expected %0b, actual %0b", want.run_last, out_run_last);
                    fail_count++;
                end
                if (out_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Writes one configuration register and mirrors it in the model.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SYNC_FIRST:     cfg_model.sync_first     = value;
            REG_SYNC_SECOND:    cfg_model.sync_second    = value;
            REG_FORMAT_VERSION: cfg_model.format_version = value;
            REG_MAX_PAYLOAD:    cfg_model.max_payload    = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] s0, input logic [7:0] s1,
                                input logic [7:0] ver, input logic [7:0] max_len);
        write_reg(REG_SYNC_FIRST, s0);
        write_reg(REG_SYNC_SECOND, s1);
        write_reg(REG_FORMAT_VERSION, ver);
        write_reg(REG_MAX_PAYLOAD, max_len);
    endtask

    // Sends one input beat, idling first at random; valid stays high until
    // the beat is taken and is left high for a following beat.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        predict_beats(it);
        items_sent++;
    endtask

    // Lowers valid and waits until every predicted beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (frame_beats_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic t_item start_item(input logic [7:0] count, input logic [15:0] room_bytes);
        t_item it;
        it.func          = FUNC_START;
        it.frame_type    = 8'($urandom_range(255));
        it.sequence_req  = 16'($urandom_range(65535));
        it.payload_count = count;
        it.room          = room_bytes;
        it.payload_byte  = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic t_item data_item(input logic [7:0] data);
        t_item it;
        it.func          = FUNC_BYTE;
        it.frame_type    = 8'($urandom_range(255));
        it.sequence_req  = 16'($urandom_range(65535));
        it.payload_count = 8'($urandom_range(255));
        it.room          = 16'($urandom_range(65535));
        it.payload_byte  = data;
        return it;
    endfunction

    // An empty frame with the register values left by reset, room just enough.
    task automatic test_reset_defaults();
        send_item(start_item(8'd0, 16'd9));
        drain();
    endtask

    // Extreme register values and header fields at both ends of their range.
    task automatic test_register_extremes();
        t_item it;
        write_config(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(start_item(8'd1, 16'hFFFF));
        it = start_item(8'd0, 16'hFFFF);
        it.frame_type   = 8'hFF;
        it.sequence_req = 16'hFFFF;
        send_item(it);
        drain();
        write_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        it = start_item(8'd0, 16'd9);
        it.frame_type   = 8'h00;
        it.sequence_req = 16'h0000;
        send_item(it);
        drain();
    endtask

    // Room boundaries, a short frame with extreme payload bytes, and the
    // length check taking priority over the room check.
    task automatic test_length_and_room_checks();
        send_item(start_item(8'd200, 16'd0));
        send_item(start_item(8'd255, 16'd263));
        send_item(start_item(8'd0, 16'd8));
        send_item(start_item(8'd5, 16'd14));
        send_item(data_item(8'h00));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hA5));
        send_item(data_item(8'h5A));
        send_item(data_item(8'h80));
        drain();
        write_reg(REG_MAX_PAYLOAD, 8'd10);
        send_item(start_item(8'd11, 16'd0));
        drain();
    endtask

    // Payload bytes with no frame open, before and after a frame.
    task automatic test_stray_bytes();
        send_item(data_item(8'h3C));
        send_item(start_item(8'd1, 16'd10));
        send_item(data_item(8'hC3));
        send_item(data_item(8'h7E));
        drain();
    endtask

    // A start while a frame is open abandons it; a rejected start does not.
    task automatic test_abandoned_frames();
        send_item(start_item(8'd4, 16'd500));
        send_item(data_item(8'h11));
        send_item(data_item(8'h22));
        send_item(start_item(8'd1, 16'd10));
        send_item(data_item(8'h33));
        send_item(start_item(8'd3, 16'd12));
        send_item(data_item(8'h44));
        send_item(start_item(8'd2, 16'd0));
        send_item(data_item(8'h55));
        send_item(data_item(8'h66));
        drain();
    endtask

    function automatic logic [7:0] pick_length(input logic [7:0] max_len);
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 70)      len = $urandom_range(6);
        else if (r < 98) len = $urandom_range(40, 7);
        else             len = $urandom_range(255, 41);
        if (len > max_len) len = $urandom_range(max_len);
        return len[7:0];
    endfunction

    // Random traffic: mostly complete frames with random content, the rest
    // rejected starts, stray bytes and frames cut short.
    task automatic test_random_frames(input int send_pct, input int recv_pct,
                                      input logic [7:0] max_len, input int target);
        int          start_count;
        int          pick;
        int          cut;
        logic [7:0]  len;
        start_count = items_sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), max_len);
        while (items_sent - start_count < target) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                len = pick_length(max_len);
                send_item(start_item(len, 16'($urandom_range(65535, int'(len) + 9))));
                repeat (len) send_item(data_item(8'($urandom_range(255))));
            end else if (pick < 84 && max_len != 8'hFF) begin
                send_item(start_item(8'($urandom_range(255, int'(max_len) + 1)),
                                     16'($urandom_range(65535))));
            end else if (pick < 90) begin
                len = 8'($urandom_range(max_len));
                send_item(start_item(len, 16'($urandom_range(int'(len) + 8))));
            end else if (pick < 95) begin
                send_item(data_item(8'($urandom_range(255))));
            end else begin
                len = pick_length(max_len);
                if (len < 8'd2) len = (max_len < 8'd2) ? max_len : 8'd2;
                cut = (len > 8'd1) ? $urandom_range(int'(len) - 1, 1) : 0;
                send_item(start_item(len, 16'($urandom_range(65535, int'(len) + 9))));
                repeat (cut) send_item(data_item(8'($urandom_range(255))));
            end
        end
        drain();
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_length_and_room_checks();
        test_stray_bytes();
        test_abandoned_frames();
        test_random_frames(11, 81, 8'hFF, 100);
        test_random_frames(81, 11, 8'($urandom_range(60, 1)), 100);
        test_random_frames(0, 0, 8'hFF, 100);
        repeat (10) @(posedge clk);
        $display("Sent %0d input beats and checked %0d output beats: %0d frames closed,",
                 items_sent, beats_checked, frames_closed);
        $display("%0d error beats, under three sender and receiver stall mixes.", error_beats);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
